>>> src/hcc_pkg.sv
// ----------------------------------------------------------------------------
// hcc_pkg
// Shared types and constants for the Huffman cost calculator.
// ----------------------------------------------------------------------------
`default_nettype none

package hcc_pkg;

  // Result field width and its saturation value
  localparam int OUT_W   = 19;
  localparam int OUT_MAX = 524287;

  // Eight bits per letter in the uncompressed size
  localparam int LETTER_SHIFT = 3;

  // Letter field width
  localparam int LETTER_W = 5;

  // Controller states
  typedef enum logic [2:0] {
    ST_COUNT,
    ST_LOAD,
    ST_SCAN,
    ST_WR_LO,
    ST_WR_HI,
    ST_DONE
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic count_en;   // a letter transfer happens this cycle
    logic load;       // copy one nonzero count into the weight store
    logic scan;       // minimum search over the live weights
    logic wr_lo;      // write the joined weight, add it to the cost
    logic wr_hi;      // move the last live weight into the freed slot
    logic finish;     // load the result register, clear the message
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic load_last;  // load sweep is at the last letter
    logic scan_done;  // all live weights have been compared
    logic live_gt1;   // more than one live weight remains
    logic out_free;   // result register can take a new result
  } status_t;

endpackage

`default_nettype wire

>>> src/hcc_ctrl.sv
// ----------------------------------------------------------------------------
// hcc_ctrl
// Controller for the Huffman cost calculator: counting, load sweep,
// merge rounds and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module hcc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             last_i,
  input  wire hcc_pkg::status_t status_i,
  output logic                  in_ready_o,
  output hcc_pkg::cmd_t         cmd_o
);

  hcc_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hcc_pkg::ST_COUNT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hcc_pkg::ST_COUNT: begin
        if (in_valid_i && last_i) state_d = hcc_pkg::ST_LOAD;
      end
      hcc_pkg::ST_LOAD: begin
        if (status_i.load_last) state_d = hcc_pkg::ST_SCAN;
      end
      hcc_pkg::ST_SCAN: begin
        priority if (!status_i.live_gt1) state_d = hcc_pkg::ST_DONE;
        else if (status_i.scan_done)     state_d = hcc_pkg::ST_WR_LO;
        else                             state_d = hcc_pkg::ST_SCAN;
      end
      hcc_pkg::ST_WR_LO: state_d = hcc_pkg::ST_WR_HI;
      hcc_pkg::ST_WR_HI: state_d = hcc_pkg::ST_SCAN;
      hcc_pkg::ST_DONE: begin
        if (status_i.out_free) state_d = hcc_pkg::ST_COUNT;
      end
      default: state_d = hcc_pkg::ST_COUNT;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      hcc_pkg::ST_COUNT: begin
        in_ready_o     = 1'b1;
        cmd_o.count_en = in_valid_i;
      end
      hcc_pkg::ST_LOAD:  cmd_o.load = 1'b1;
      hcc_pkg::ST_SCAN:  cmd_o.scan = status_i.live_gt1;
      hcc_pkg::ST_WR_LO: cmd_o.wr_lo = 1'b1;
      hcc_pkg::ST_WR_HI: cmd_o.wr_hi = 1'b1;
      hcc_pkg::ST_DONE:  cmd_o.finish = status_i.out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/hcc_datapath.sv
// ----------------------------------------------------------------------------
// hcc_datapath
// Letter counters, merge weight store, two-minimum search, cost
// accumulator and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hcc_datapath #(
  parameter int ALPHABET_SIZE = 26,
  parameter int MAX_LETTERS   = 65535
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire hcc_pkg::cmd_t                cmd_i,
  output hcc_pkg::status_t                  status_o,
  input  wire logic [hcc_pkg::LETTER_W-1:0] letter_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [hcc_pkg::OUT_W-1:0]         original_bits_o,
  output logic [hcc_pkg::OUT_W-1:0]         compressed_bits_o,
  output logic                              overflow_o
);

  localparam int CNT_W   = $clog2(MAX_LETTERS + 1);
  localparam int IDX_W   = $clog2(ALPHABET_SIZE);
  localparam int LIVE_W  = $clog2(ALPHABET_SIZE + 1);
  localparam int JOIN_W  = CNT_W + 1;
  localparam int SUM_W   = ((hcc_pkg::OUT_W > JOIN_W) ? hcc_pkg::OUT_W : JOIN_W) + 1;
  localparam int ORIG_W  = CNT_W + hcc_pkg::LETTER_SHIFT;
  localparam int ORIGC_W = (ORIG_W > hcc_pkg::OUT_W) ? ORIG_W : hcc_pkg::OUT_W;

  // --------------------------------------------------------------------------
  // Letter counting
  // --------------------------------------------------------------------------
  logic [31:0]      letter_ext;
  logic             in_range;
  logic             full;
  logic             cnt_inc;
  logic [CNT_W-1:0] cnt_q [ALPHABET_SIZE];
  logic [CNT_W-1:0] total_q;
  logic             drop_q;

  assign letter_ext = 32'(letter_i);
  assign in_range   = letter_ext < 32'(ALPHABET_SIZE);
  assign full       = total_q >= CNT_W'(MAX_LETTERS);
  assign cnt_inc    = cmd_i.count_en && in_range && !full;

  // One counter per letter, cleared after each result
  for (genvar g = 0; g < ALPHABET_SIZE; g++) begin : g_cnt
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q[g] <= '0;
      end else if (cmd_i.finish) begin
        cnt_q[g] <= '0;
      end else if (cnt_inc && (letter_ext == 32'(g))) begin
        cnt_q[g] <= cnt_q[g] + CNT_W'(1);
      end
    end
  end

  // Total letters and dropped flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      drop_q  <= 1'b0;
    end else if (cmd_i.finish) begin
      total_q <= '0;
      drop_q  <= 1'b0;
    end else if (cmd_i.count_en && in_range) begin
      if (full) begin
        drop_q <= 1'b1;
      end else begin
        total_q <= total_q + CNT_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sweep index and live weight count
  // --------------------------------------------------------------------------
  logic [LIVE_W-1:0] idx_q;
  logic [LIVE_W-1:0] live_q;
  logic [CNT_W-1:0]  load_cnt;
  logic              load_nz;
  logic              load_last;
  logic              rd_issue;

  assign load_cnt  = cnt_q[idx_q[IDX_W-1:0]];
  assign load_nz   = load_cnt != '0;
  assign load_last = idx_q == LIVE_W'(ALPHABET_SIZE - 1);
  assign rd_issue  = cmd_i.scan && (idx_q < live_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      live_q <= '0;
    end else begin
      if (cmd_i.finish) begin
        idx_q  <= '0;
        live_q <= '0;
      end else if (cmd_i.load) begin
        idx_q <= load_last ? '0 : idx_q + LIVE_W'(1);
        if (load_nz) live_q <= live_q + LIVE_W'(1);
      end else if (rd_issue) begin
        idx_q <= idx_q + LIVE_W'(1);
      end else if (cmd_i.wr_hi) begin
        idx_q  <= '0;
        live_q <= live_q - LIVE_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Merge weight store: one write port, one registered read port
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] mw_q [ALPHABET_SIZE];
  logic             mw_we;
  logic [IDX_W-1:0] mw_waddr;
  logic [CNT_W-1:0] mw_wdata;
  logic [CNT_W-1:0] rd_data_q;
  logic             rd_vld_q;
  logic [LIVE_W-1:0] rd_k_q;

  logic [IDX_W-1:0]  a_idx_q, b_idx_q;
  logic [CNT_W-1:0]  a_w_q, b_w_q;
  logic              a_vld_q, b_vld_q;
  logic [CNT_W-1:0]  last_w_q;
  logic [JOIN_W-1:0] joined;
  logic [IDX_W-1:0]  lo_idx, hi_idx;

  assign joined = JOIN_W'(a_w_q) + JOIN_W'(b_w_q);
  assign lo_idx = (a_idx_q < b_idx_q) ? a_idx_q : b_idx_q;
  assign hi_idx = (a_idx_q < b_idx_q) ? b_idx_q : a_idx_q;

  // Write port select
  always_comb begin
    mw_we    = 1'b0;
    mw_waddr = live_q[IDX_W-1:0];
    mw_wdata = load_cnt;
    if (cmd_i.load) begin
      mw_we = load_nz;
    end else if (cmd_i.wr_lo) begin
      mw_we    = 1'b1;
      mw_waddr = lo_idx;
      mw_wdata = CNT_W'(joined);
    end else if (cmd_i.wr_hi) begin
      mw_we    = 1'b1;
      mw_waddr = hi_idx;
      mw_wdata = last_w_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mw_we) mw_q[mw_waddr] <= mw_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      rd_data_q <= mw_q[idx_q[IDX_W-1:0]];
      rd_k_q    <= idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_issue;
    end
  end

  // --------------------------------------------------------------------------
  // Two-minimum search over the read stream
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (cmd_i.load || cmd_i.wr_hi) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (rd_vld_q) begin
      if (!a_vld_q || (rd_data_q < a_w_q)) begin
        a_vld_q <= 1'b1;
        b_vld_q <= a_vld_q;
      end else if (!b_vld_q || (rd_data_q < b_w_q)) begin
        b_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      if (!a_vld_q || (rd_data_q < a_w_q)) begin
        b_idx_q <= a_idx_q;
        b_w_q   <= a_w_q;
        a_idx_q <= rd_k_q[IDX_W-1:0];
        a_w_q   <= rd_data_q;
      end else if (!b_vld_q || (rd_data_q < b_w_q)) begin
        b_idx_q <= rd_k_q[IDX_W-1:0];
        b_w_q   <= rd_data_q;
      end
      // keep the last live weight for the refill write
      if (rd_k_q == (live_q - LIVE_W'(1))) last_w_q <= rd_data_q;
    end
  end

  // --------------------------------------------------------------------------
  // Cost accumulator, saturating at the result width
  // --------------------------------------------------------------------------
  logic [hcc_pkg::OUT_W-1:0] cost_q;
  logic [SUM_W-1:0]          cost_sum;

  assign cost_sum = SUM_W'(cost_q) + SUM_W'(joined);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_q <= '0;
    end else if (cmd_i.finish) begin
      cost_q <= '0;
    end else if (cmd_i.wr_lo) begin
      if (cost_sum > SUM_W'(hcc_pkg::OUT_MAX)) begin
        cost_q <= hcc_pkg::OUT_W'(hcc_pkg::OUT_MAX);
      end else begin
        cost_q <= cost_sum[hcc_pkg::OUT_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic [ORIGC_W-1:0]        orig_ext;
  logic [hcc_pkg::OUT_W-1:0] orig_sat;
  logic                      out_valid_q;

  assign orig_ext = ORIGC_W'(ORIG_W'(total_q) << hcc_pkg::LETTER_SHIFT);
  assign orig_sat = (orig_ext > ORIGC_W'(hcc_pkg::OUT_MAX)) ?
                    hcc_pkg::OUT_W'(hcc_pkg::OUT_MAX) : orig_ext[hcc_pkg::OUT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      original_bits_o   <= orig_sat;
      compressed_bits_o <= cost_q;
      overflow_o        <= drop_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // Status to the controller
  assign status_o.load_last = load_last;
  assign status_o.scan_done = (idx_q == live_q) && !rd_vld_q;
  assign status_o.live_gt1  = live_q > LIVE_W'(1);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

>>> src/huffman_cost_calculator.sv
// ----------------------------------------------------------------------------
// huffman_cost_calculator
// Counts letters of a message and, on the last letter, computes the
// original size and the optimal Huffman-coded size of the message.
//
//   Channel | Handshake               | Payload
//   --------+-------------------------+------------------------------------
//   in      | in_valid_i / in_ready_o | letter_i, last_i
//   out     | out_valid_o/out_ready_i | original_bits_o, compressed_bits_o,
//           |                         | overflow_o
//
// Letters transfer one per cycle while counting. After the last letter the
// block is busy: a load sweep over all ALPHABET_SIZE letters copies the
// nonzero counts into the weight store, then each of the L-1 merge rounds
// (L = distinct letters) reads every live weight through the single read
// port of the weight store, drains the read and makes two writes; then the
// result register is loaded. Reset clears all counters; the weight store
// needs no clearing. A result waits in the output register while counting
// of the next message goes on; a second result waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_cost_calculator #(
  parameter int ALPHABET_SIZE = 26,
  parameter int MAX_LETTERS   = 65535
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [hcc_pkg::LETTER_W-1:0] letter_i,
  input  wire logic                         last_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [hcc_pkg::OUT_W-1:0]         original_bits_o,
  output logic [hcc_pkg::OUT_W-1:0]         compressed_bits_o,
  output logic                              overflow_o
);

  hcc_pkg::cmd_t    cmd;
  hcc_pkg::status_t status;

  // Sequencer
  hcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // Counters, weight store and result
  hcc_datapath #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .MAX_LETTERS   (MAX_LETTERS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .letter_i          (letter_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .original_bits_o   (original_bits_o),
    .compressed_bits_o (compressed_bits_o),
    .overflow_o        (overflow_o)
  );

endmodule

`default_nettype wire
